// ----- rtl/pkvs_pkg.sv -----
// Shared types, codes and default sizes for the paged key/value record store.
// No dependencies; other files refer to this package by scoped names.
`default_nettype none
package pkvs_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned PAGES_DEF   = 256;

  localparam logic [2:0] FN_ALLOC = 3'd0;
  localparam logic [2:0] FN_PUT   = 3'd1;
  localparam logic [2:0] FN_GET   = 3'd2;
  localparam logic [2:0] FN_DUMP  = 3'd3;
  localparam logic [2:0] FN_SPLIT = 3'd4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_BAD_PAGE  = 3'd3;
  localparam logic [2:0] STAT_NO_FREE   = 3'd4;
  localparam logic [2:0] STAT_EMPTY     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD,
    ST_CHK,
    ST_SPLIT_FIN,
    ST_OUT
  } state_t;

  // Results of the shared key comparator.
  typedef struct packed {
    logic eq0;
    logic lt0;
    logic lt1;
  } cmp_res_t;

endpackage
`default_nettype wire

// ----- rtl/pkvs_if.sv -----
// Valid/ready channel interfaces for request and result beats.
// Depends on nothing but fixed field widths.
`default_nettype none
interface pkvs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  page;
  logic [63:0] key;
  logic [63:0] value;
  modport source (output valid, func, page, key, value, input ready);
  modport sink   (input valid, func, page, key, value, output ready);
endinterface

interface pkvs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_key;
  logic [63:0] out_value;
  logic [7:0]  new_page;
  logic        last;
  modport source (output valid, status, out_key, out_value, new_page, last, input ready);
  modport sink   (input valid, status, out_key, out_value, new_page, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/pkvs_rec_mem.sv -----
// Record storage: key and value arrays with one write port and a registered read.
// Depends on nothing; the address width comes from the top level.
`default_nettype none
module pkvs_rec_mem #(
  parameter int unsigned AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   wkey,
  input  wire logic [63:0]   wval,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rkey,
  output logic      [63:0]   rval
);
  logic [63:0] key_mem [2**AW];
  logic [63:0] val_mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/pkvs_cmp.sv -----
// Shared 64-bit key comparator used by every scan of the sequencer.
// Depends on pkvs_pkg for its result struct.
`default_nettype none
module pkvs_cmp (
  input  wire logic [63:0] cand,
  input  wire logic [63:0] ref0,
  input  wire logic [63:0] ref1,
  output pkvs_pkg::cmp_res_t res
);
  assign res.eq0 = (cand == ref0);
  assign res.lt0 = (cand < ref0);
  assign res.lt1 = (cand < ref1);
endmodule
`default_nettype wire

// ----- rtl/paged_key_value_record_store.sv -----
// Paged key/value record store, one request at a time under a sequencer. Alloc, bad page
// and no-free-page results come straight from idle; other requests read the page's fill
// count, then scan its records. Put/get stop at the first match; split reads every record;
// dump makes one full pass over the page per result beat. The next request is accepted in
// the cycle after the last beat is taken.
// Synchronous active-low reset empties the store at once (page count cleared).
`default_nettype none
module paged_key_value_record_store #(
  parameter int unsigned ENTRIES = pkvs_pkg::ENTRIES_DEF,
  parameter int unsigned PAGES   = pkvs_pkg::PAGES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pkvs_in_if.sink         in_ch,
  pkvs_out_if.source      out_ch
);
  // Index of a record in a page, fill count, page id, allocation count widths.
  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FW  = $clog2(ENTRIES + 1);
  localparam int unsigned PW  = $clog2(PAGES);
  localparam int unsigned ACW = $clog2(PAGES + 1);
  localparam int unsigned AW  = PW + IW;
  localparam int unsigned CW  = ACW + 8;

  pkvs_pkg::state_t state_r, state_nxt;

  logic [ACW-1:0] alloc_r, alloc_nxt;
  logic [2:0]     func_r, func_nxt;
  logic [PW-1:0]  page_r, page_nxt;
  logic [PW-1:0]  np_r, np_nxt;
  logic [63:0]    key_r, key_nxt;
  logic [63:0]    val_r, val_nxt;
  logic [FW-1:0]  n_r, n_nxt;
  logic [FW-1:0]  idx_r, idx_nxt;
  logic [FW-1:0]  lc_r, lc_nxt;
  logic [FW-1:0]  rc_r, rc_nxt;
  logic [FW-1:0]  rank_r, rank_nxt;
  logic [63:0]    prev_key_r, prev_key_nxt;
  logic [FW-1:0]  prev_idx_r, prev_idx_nxt;
  logic           best_v_r, best_v_nxt;
  logic [63:0]    best_key_r, best_key_nxt;
  logic [63:0]    best_val_r, best_val_nxt;
  logic [FW-1:0]  best_idx_r, best_idx_nxt;

  // Result beat register.
  logic           ov_r, ov_nxt;
  logic [2:0]     ost_r, ost_nxt;
  logic [63:0]    okey_r, okey_nxt;
  logic [63:0]    oval_r, oval_nxt;
  logic [7:0]     onp_r, onp_nxt;
  logic           olast_r, olast_nxt;

  // Record memory port.
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [63:0]    mem_wkey, mem_wval;
  logic [AW-1:0]  mem_raddr;
  logic [63:0]    rd_key, rd_val;

  // Per-page fill count memory; only the counts of allocated pages are used, and alloc writes zero.
  logic [FW-1:0]  fill_mem [PAGES];
  logic           fill_we;
  logic [PW-1:0]  fill_waddr, fill_raddr;
  logic [FW-1:0]  fill_wdata, fill_q;

  pkvs_pkg::cmp_res_t cmp;
  logic [63:0]    cmp_ref0;

  // Emission of a result beat from the sequencer.
  logic           emit;
  logic [2:0]     e_st;
  logic [63:0]    e_key, e_val;
  logic [7:0]     e_np;
  logic           e_last;

  logic           store_full, page_ok, gt_prev, take;

  pkvs_rec_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (mem_wkey),
    .wval  (mem_wval),
    .raddr (mem_raddr),
    .rkey  (rd_key),
    .rval  (rd_val)
  );

  // During a dump the comparator checks the candidate against the last emitted key
  // and against the best candidate of this pass; otherwise against the request key.
  assign cmp_ref0 = (func_r == pkvs_pkg::FN_DUMP) ? prev_key_r : key_r;

  pkvs_cmp u_cmp (
    .cand (rd_key),
    .ref0 (cmp_ref0),
    .ref1 (best_key_r),
    .res  (cmp)
  );

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_q <= fill_mem[fill_raddr];
  end

  assign store_full = (alloc_r >= ACW'(PAGES));
  assign page_ok    = (CW'(in_ch.page) < CW'(alloc_r));

  // Dump emits records ordered by (key, index), which is the stable sort order. A
  // candidate qualifies when it follows the last emitted record in that order.
  assign gt_prev = (rank_r == '0) || (!cmp.lt0 && !cmp.eq0) || (cmp.eq0 && idx_r > prev_idx_r);
  assign take    = gt_prev && (!best_v_r || cmp.lt1);

  assign in_ch.ready      = (state_r == pkvs_pkg::ST_IDLE);
  assign out_ch.valid     = ov_r;
  assign out_ch.status    = ost_r;
  assign out_ch.out_key   = okey_r;
  assign out_ch.out_value = oval_r;
  assign out_ch.new_page  = onp_r;
  assign out_ch.last      = olast_r;

  always_comb begin
    state_nxt    = state_r;
    alloc_nxt    = alloc_r;
    func_nxt     = func_r;
    page_nxt     = page_r;
    np_nxt       = np_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    lc_nxt       = lc_r;
    rc_nxt       = rc_r;
    rank_nxt     = rank_r;
    prev_key_nxt = prev_key_r;
    prev_idx_nxt = prev_idx_r;
    best_v_nxt   = best_v_r;
    best_key_nxt = best_key_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    ov_nxt       = ov_r;
    ost_nxt      = ost_r;
    okey_nxt     = okey_r;
    oval_nxt     = oval_r;
    onp_nxt      = onp_r;
    olast_nxt    = olast_r;

    mem_we     = 1'b0;
    mem_waddr  = {page_r, idx_r[IW-1:0]};
    mem_wkey   = key_r;
    mem_wval   = val_r;
    mem_raddr  = {page_r, idx_r[IW-1:0]};
    fill_we    = 1'b0;
    fill_waddr = page_r;
    fill_wdata = '0;
    fill_raddr = (state_r == pkvs_pkg::ST_IDLE) ? PW'(in_ch.page) : page_r;

    emit   = 1'b0;
    e_st   = pkvs_pkg::STAT_OK;
    e_key  = '0;
    e_val  = '0;
    e_np   = '0;
    e_last = 1'b1;

    unique case (state_r)
      pkvs_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          func_nxt   = in_ch.func;
          page_nxt   = PW'(in_ch.page);
          key_nxt    = in_ch.key;
          val_nxt    = in_ch.value;
          idx_nxt    = '0;
          lc_nxt     = '0;
          rc_nxt     = '0;
          rank_nxt   = '0;
          best_v_nxt = 1'b0;
          priority if (in_ch.func == pkvs_pkg::FN_ALLOC) begin
            emit = 1'b1;
            if (store_full) begin
              e_st = pkvs_pkg::STAT_NO_FREE;
            end else begin
              fill_we    = 1'b1;
              fill_waddr = PW'(alloc_r);
              e_np       = 8'(alloc_r);
              alloc_nxt  = alloc_r + ACW'(1);
            end
          end else if (in_ch.func > pkvs_pkg::FN_SPLIT) begin
            // Unknown functions are dropped without a result.
          end else if (!page_ok) begin
            emit = 1'b1;
            e_st = pkvs_pkg::STAT_BAD_PAGE;
          end else if (in_ch.func == pkvs_pkg::FN_SPLIT && store_full) begin
            emit = 1'b1;
            e_st = pkvs_pkg::STAT_NO_FREE;
          end else begin
            if (in_ch.func == pkvs_pkg::FN_SPLIT) begin
              np_nxt    = PW'(alloc_r);
              alloc_nxt = alloc_r + ACW'(1);
            end
            state_nxt = pkvs_pkg::ST_FILL;
          end
        end
      end

      pkvs_pkg::ST_FILL: begin
        n_nxt = fill_q;
        if (func_r == pkvs_pkg::FN_DUMP && fill_q == '0) begin
          emit = 1'b1;
          e_st = pkvs_pkg::STAT_EMPTY;
        end else begin
          state_nxt = pkvs_pkg::ST_RD;
        end
      end

      pkvs_pkg::ST_RD: begin
        if (idx_r != n_r) begin
          state_nxt = pkvs_pkg::ST_CHK;
        end else begin
          // The scan reached the end of the page.
          unique case (func_r)
            pkvs_pkg::FN_PUT: begin
              emit = 1'b1;
              if (n_r >= FW'(ENTRIES)) begin
                e_st = pkvs_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = {page_r, n_r[IW-1:0]};
                fill_we    = 1'b1;
                fill_wdata = n_r + FW'(1);
              end
            end
            pkvs_pkg::FN_GET: begin
              emit = 1'b1;
              e_st = pkvs_pkg::STAT_NOT_FOUND;
            end
            pkvs_pkg::FN_SPLIT: begin
              fill_we    = 1'b1;
              fill_wdata = lc_r;
              state_nxt  = pkvs_pkg::ST_SPLIT_FIN;
            end
            default: begin
              // Dump: the pass found the next record in key order.
              emit         = 1'b1;
              e_key        = best_key_r;
              e_val        = best_val_r;
              e_last       = (rank_r + FW'(1) == n_r);
              prev_key_nxt = best_key_r;
              prev_idx_nxt = best_idx_r;
              rank_nxt     = rank_r + FW'(1);
            end
          endcase
        end
      end

      pkvs_pkg::ST_CHK: begin
        idx_nxt   = idx_r + FW'(1);
        state_nxt = pkvs_pkg::ST_RD;
        unique case (func_r)
          pkvs_pkg::FN_PUT: begin
            if (cmp.eq0) begin
              mem_we = 1'b1;
              emit   = 1'b1;
            end
          end
          pkvs_pkg::FN_GET: begin
            if (cmp.eq0) begin
              emit  = 1'b1;
              e_val = rd_val;
            end
          end
          pkvs_pkg::FN_SPLIT: begin
            // Left writes never pass the read position, so unread records survive.
            mem_we   = 1'b1;
            mem_wkey = rd_key;
            mem_wval = rd_val;
            if (cmp.lt0) begin
              mem_waddr = {page_r, lc_r[IW-1:0]};
              lc_nxt    = lc_r + FW'(1);
            end else begin
              mem_waddr = {np_r, rc_r[IW-1:0]};
              rc_nxt    = rc_r + FW'(1);
            end
          end
          default: begin
            if (take) begin
              best_v_nxt   = 1'b1;
              best_key_nxt = rd_key;
              best_val_nxt = rd_val;
              best_idx_nxt = idx_r;
            end
          end
        endcase
      end

      pkvs_pkg::ST_SPLIT_FIN: begin
        fill_we    = 1'b1;
        fill_waddr = np_r;
        fill_wdata = rc_r;
        emit       = 1'b1;
        e_np       = 8'(np_r);
      end

      pkvs_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          ov_nxt = 1'b0;
          if (func_r == pkvs_pkg::FN_DUMP && !olast_r) begin
            idx_nxt    = '0;
            best_v_nxt = 1'b0;
            state_nxt  = pkvs_pkg::ST_RD;
          end else begin
            state_nxt = pkvs_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = pkvs_pkg::ST_IDLE;
      end
    endcase

    if (emit) begin
      ov_nxt    = 1'b1;
      ost_nxt   = e_st;
      okey_nxt  = e_key;
      oval_nxt  = e_val;
      onp_nxt   = e_np;
      olast_nxt = e_last;
      state_nxt = pkvs_pkg::ST_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pkvs_pkg::ST_IDLE;
      alloc_r  <= '0;
      ov_r     <= 1'b0;
      best_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      alloc_r  <= alloc_nxt;
      ov_r     <= ov_nxt;
      best_v_r <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    page_r     <= page_nxt;
    np_r       <= np_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    lc_r       <= lc_nxt;
    rc_r       <= rc_nxt;
    rank_r     <= rank_nxt;
    prev_key_r <= prev_key_nxt;
    prev_idx_r <= prev_idx_nxt;
    best_key_r <= best_key_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    ost_r      <= ost_nxt;
    okey_r     <= okey_nxt;
    oval_r     <= oval_nxt;
    onp_r      <= onp_nxt;
    olast_r    <= olast_nxt;
  end
endmodule
`default_nettype wire

// ----- tb/sv/pkvs_tb_if.sv -----
// Testbench types: the expected result beat kept by the checker.
// Depends on nothing; the channel interfaces come from the RTL file pkvs_if.sv.
package pkvs_tb_types;

  // One expected result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] rkey;
    logic [63:0] rval;
    logic [7:0]  npage;
    logic        fin;
  } result_beat_t;
endpackage

// ----- tb/sv/pkvs_checker.sv -----
// Watches the request and result channels, predicts the store and compares beats.
// Depends on pkvs_pkg, pkvs_tb_types and the channel interfaces.
module pkvs_checker (
  input  logic        clk,
  input  logic        rst_n,
  pkvs_in_if.sink     req_mon,
  pkvs_out_if.sink    rsp_mon,
  output int          errors,
  output int          pending
);
  localparam int NREC = 16;
  localparam int NPG  = 256;

  logic [63:0] keys_mem [NPG][NREC];
  logic [63:0] vals_mem [NPG][NREC];
  int          fill [NPG];
  int          npages;
  pkvs_tb_types::result_beat_t expected_beats [$];

  function automatic pkvs_tb_types::result_beat_t mk(logic [2:0] s, logic [63:0] k,
                                                     logic [63:0] v, logic [7:0] p,
                                                     logic f);
    pkvs_tb_types::result_beat_t r;
    r.status = s; r.rkey = k; r.rval = v; r.npage = p; r.fin = f;
    return r;
  endfunction

  // Appends one expected beat at the tail of the queue.
  function automatic void queue_beat(pkvs_tb_types::result_beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  task automatic apply_request(logic [2:0] fn, logic [7:0] pg, logic [63:0] k,
                               logic [63:0] v);
    int n, i, j, lc, rc, np, cur;
    bit hit;
    int ord [NREC];
    logic [63:0] tk [NREC];
    logic [63:0] tv [NREC];
    hit = 0;
    if (fn == pkvs_pkg::FN_ALLOC) begin
      if (npages >= NPG) queue_beat(mk(pkvs_pkg::STAT_NO_FREE, 0, 0, 0, 1));
      else begin
        fill[npages] = 0;
        queue_beat(mk(pkvs_pkg::STAT_OK, 0, 0, npages[7:0], 1));
        npages++;
      end
      return;
    end
    if (fn > pkvs_pkg::FN_SPLIT) return;
    if (int'(pg) >= npages) begin
      queue_beat(mk(pkvs_pkg::STAT_BAD_PAGE, 0, 0, 0, 1));
      return;
    end
    n = fill[pg];
    case (fn)
      pkvs_pkg::FN_PUT: begin
        for (i = 0; i < n; i++)
          if (!hit && keys_mem[pg][i] == k) begin
            vals_mem[pg][i] = v;
            hit = 1;
          end
        if (hit) queue_beat(mk(pkvs_pkg::STAT_OK, 0, 0, 0, 1));
        else if (n >= NREC) queue_beat(mk(pkvs_pkg::STAT_FULL, 0, 0, 0, 1));
        else begin
          keys_mem[pg][n] = k;
          vals_mem[pg][n] = v;
          fill[pg] = n + 1;
          queue_beat(mk(pkvs_pkg::STAT_OK, 0, 0, 0, 1));
        end
      end
      pkvs_pkg::FN_GET: begin
        for (i = 0; i < n; i++)
          if (!hit && keys_mem[pg][i] == k) begin
            queue_beat(mk(pkvs_pkg::STAT_OK, 0, vals_mem[pg][i], 0, 1));
            hit = 1;
          end
        if (!hit) queue_beat(mk(pkvs_pkg::STAT_NOT_FOUND, 0, 0, 0, 1));
      end
      pkvs_pkg::FN_DUMP: begin
        if (n == 0) queue_beat(mk(pkvs_pkg::STAT_EMPTY, 0, 0, 0, 1));
        else begin
          // Stable insertion sort of record indexes by key.
          for (i = 0; i < n; i++) begin
            cur = i;
            j = i;
            while (j > 0 && keys_mem[pg][ord[j-1]] > keys_mem[pg][cur]) begin
              ord[j] = ord[j-1];
              j--;
            end
            ord[j] = cur;
          end
          for (i = 0; i < n; i++)
            queue_beat(mk(pkvs_pkg::STAT_OK, keys_mem[pg][ord[i]],
                          vals_mem[pg][ord[i]], 0, i == n - 1));
        end
      end
      default: begin
        if (npages >= NPG) queue_beat(mk(pkvs_pkg::STAT_NO_FREE, 0, 0, 0, 1));
        else begin
          np = npages++;
          lc = 0; rc = 0;
          for (i = 0; i < n; i++) begin
            tk[i] = keys_mem[pg][i];
            tv[i] = vals_mem[pg][i];
          end
          for (i = 0; i < n; i++)
            if (tk[i] < k) begin
              keys_mem[pg][lc] = tk[i]; vals_mem[pg][lc] = tv[i]; lc++;
            end else begin
              keys_mem[np][rc] = tk[i]; vals_mem[np][rc] = tv[i]; rc++;
            end
          fill[pg] = lc;
          fill[np] = rc;
          queue_beat(mk(pkvs_pkg::STAT_OK, 0, 0, np[7:0], 1));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    pkvs_tb_types::result_beat_t exp_b;
    if (!rst_n) begin
      npages = 0;
      expected_beats.delete();
      errors = 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        apply_request(req_mon.func, req_mon.page, req_mon.key, req_mon.value);
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat, status %0d", rsp_mon.status);
        end else begin
          exp_b = expected_beats.pop_front();
          if (exp_b.status !== rsp_mon.status || exp_b.rkey !== rsp_mon.out_key ||
              exp_b.rval !== rsp_mon.out_value || exp_b.npage !== rsp_mon.new_page ||
              exp_b.fin !== rsp_mon.last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp st=%0d k=%h v=%h np=%0d l=%0d",
                        " got st=%0d k=%h v=%h np=%0d l=%0d"},
                       exp_b.status, exp_b.rkey, exp_b.rval, exp_b.npage, exp_b.fin,
                       rsp_mon.status, rsp_mon.out_key, rsp_mon.out_value,
                       rsp_mon.new_page, rsp_mon.last);
          end
        end
      end
    end
    pending = expected_beats.size();
  end
endmodule

// ----- tb/sv/testbench.sv -----
// Top of the testbench: clock, reset, request stimulus, result back-pressure, verdict.
// Depends on pkvs_pkg, the channel interfaces, pkvs_checker and the store itself.
module testbench;
  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   idle_cycles;
  int   n_sent;
  bit   stim_done;
  bit   long_hold;

  pkvs_in_if  req_ch ();
  pkvs_out_if rsp_ch ();

  paged_key_value_record_store dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (rsp_ch.source)
  );

  pkvs_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_mon (req_ch.sink),
    .rsp_mon (rsp_ch.sink),
    .errors  (errors),
    .pending (pending)
  );

  // Pages handed out so far, tracked here so stimulus mostly targets live pages.
  int live_pages;
  // A small pool of keys per run makes puts hit existing records and gets succeed.
  logic [63:0] key_pool [8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sends one request beat after a random gap and holds it until accepted. Valid stays
  // high after the beat when the next request follows without a gap.
  task automatic send_request(logic [2:0] fn, logic [7:0] pg, logic [63:0] k,
                              logic [63:0] v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= fn;
    req_ch.page  <= pg;
    req_ch.key   <= k;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_sent++;
    if ((fn == pkvs_pkg::FN_ALLOC || (fn == pkvs_pkg::FN_SPLIT && int'(pg) < live_pages)) &&
        live_pages < 256)
      live_pages++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] pick_page();
    if (live_pages == 0 || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, live_pages - 1));
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 3) == 0) return rand64();
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // Receiver: random stalls per beat, and one long hold-off while requests keep coming.
  initial begin
    int wait_n;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (1) begin
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      if (wait_n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: cycles with no accepted beat on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int i, k;
    logic [2:0] fn;
    idle_cycles = 0;
    n_sent = 0;
    stim_done = 0;
    long_hold = 0;
    live_pages = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func = pkvs_pkg::FN_ALLOC;
    req_ch.page = '0;
    req_ch.key = '0;
    req_ch.value = '0;
    for (i = 0; i < 8; i++) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unallocated pages, an empty dump, the full page, lookups and a split.
    send_request(pkvs_pkg::FN_GET, 8'd0, 64'd1, 64'd0);
    send_request(pkvs_pkg::FN_DUMP, 8'd255, 64'd0, 64'd0);
    send_request(pkvs_pkg::FN_ALLOC, 8'd0, 64'd0, 64'd0);
    send_request(pkvs_pkg::FN_DUMP, 8'd0, 64'd0, 64'd0);
    send_request(pkvs_pkg::FN_SPLIT, 8'd0, 64'd5, 64'd0);
    for (i = 0; i < 16; i++)
      send_request(pkvs_pkg::FN_PUT, 8'd0, (i == 0) ? '1 : 64'(16 - i),
                   (i == 1) ? '1 : 64'(i));
    send_request(pkvs_pkg::FN_PUT, 8'd0, 64'd100, 64'd7);
    send_request(pkvs_pkg::FN_PUT, 8'd0, 64'd3, 64'hdead);
    send_request(pkvs_pkg::FN_GET, 8'd0, 64'd3, 64'd0);
    send_request(pkvs_pkg::FN_GET, 8'd0, 64'd0, 64'd0);
    send_request(3'd5, 8'd0, 64'd0, 64'd0);
    send_request(3'd7, 8'hff, '1, '1);
    send_request(pkvs_pkg::FN_DUMP, 8'd0, 64'd0, 64'd0);
    send_request(pkvs_pkg::FN_SPLIT, 8'd0, 64'd8, 64'd0);
    send_request(pkvs_pkg::FN_DUMP, 8'd2, 64'd0, 64'd0);

    // Random: mostly well-formed traffic over live pages with a small key pool. The
    // loop leaves room for the allocs that exhaust the store, about 370 requests in all.
    i = 0;
    while (n_sent + (256 - live_pages) < 366) begin
      if (i == 40) long_hold = 1;
      k = $urandom_range(0, 99);
      if (k < 4) fn = pkvs_pkg::FN_ALLOC;
      else if (k < 50) fn = pkvs_pkg::FN_PUT;
      else if (k < 75) fn = pkvs_pkg::FN_GET;
      else if (k < 85) fn = pkvs_pkg::FN_DUMP;
      else if (k < 95) fn = pkvs_pkg::FN_SPLIT;
      else fn = 3'($urandom_range(5, 7));
      send_request(fn, pick_page(), pick_key(), rand64());
      i++;
    end
    // Exhaust the store so that alloc and split run out of pages.
    while (live_pages < 256) send_request(pkvs_pkg::FN_ALLOC, 8'd0, 64'd0, 64'd0);
    send_request(pkvs_pkg::FN_ALLOC, 8'd0, 64'd0, 64'd0);
    send_request(pkvs_pkg::FN_SPLIT, 8'd0, 64'd8, 64'd0);
    send_request(pkvs_pkg::FN_PUT, 8'd255, 64'd9, 64'd9);
    send_request(pkvs_pkg::FN_DUMP, 8'd255, 64'd0, 64'd0);
    req_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
